>>> hdl/bis_pkg.sv
// Shared constants, payload structs and tap control struct for the bilinear image sampler.
package bis_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FRAC_BITS  = 8;

    localparam int COORD_W = 16;
    localparam int PIX_W   = 16;
    localparam int SIZE_W  = 9;
    localparam int INT_W   = COORD_W - FRAC_BITS;
    // wide enough for coordinate + 1 and for every size bound
    localparam int CMP_W   = COORD_W + 1;
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int WGT_W   = FRAC_BITS + 1;
    localparam int W2_W    = 2 * FRAC_BITS + 1;
    localparam int ACC_W   = PIX_W + 2 * FRAC_BITS;

    localparam logic [WGT_W-1:0]  WGT_ONE      = WGT_W'(2 ** FRAC_BITS);
    localparam logic [SIZE_W-1:0] SIZE_DEFAULT = SIZE_W'(256);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic               command;
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
        logic [PIX_W-1:0]   pixel_value;
    } t_in_word;

    typedef struct packed {
        logic [PIX_W-1:0] sample_value;
        logic             write_ignored;
    } t_out_word;

    // one neighbor read handed to the blend unit alongside the memory access
    typedef struct packed {
        logic            vld;
        logic            first;
        logic            last;
        logic            in_img;
        logic [W2_W-1:0] weight;
    } t_tap;

endpackage

>>> hdl/bis_pixel_mem.sv
// Single-port pixel memory with registered read data.
module bis_pixel_mem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [bis_pkg::ADDR_W-1:0]  i_addr,
    input  logic [bis_pkg::PIX_W-1:0]   i_wdata,
    output logic [bis_pkg::PIX_W-1:0]   o_rdata
);

    logic [bis_pkg::PIX_W-1:0] r_mem [bis_pkg::DEPTH];
    logic [bis_pkg::PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/bis_blend.sv
// Weighted multiply-accumulate over the four neighbor reads of one sample.
module bis_blend (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bis_pkg::t_tap              i_tap,
    input  logic [bis_pkg::PIX_W-1:0]  i_rdata,
    output logic                       o_done,
    output logic [bis_pkg::PIX_W-1:0]  o_value
);

    bis_pkg::t_tap                 r_tap1;
    logic                          r_vld2;
    logic                          r_first2;
    logic                          r_last2;
    logic [bis_pkg::ACC_W-1:0]     r_prod;
    logic [bis_pkg::ACC_W-1:0]     r_acc;
    logic                          r_done;
    logic [bis_pkg::ACC_W-1:0]     n_prod;
    logic [bis_pkg::ACC_W-1:0]     n_acc;

    // outside neighbors contribute zero
    always_comb begin
        n_prod = '0;
        if (r_tap1.in_img) begin
            n_prod = bis_pkg::ACC_W'(i_rdata * r_tap1.weight);
        end
        n_acc = r_first2 ? r_prod : r_acc + r_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap1   <= '0;
            r_vld2   <= 1'b0;
            r_first2 <= 1'b0;
            r_last2  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_tap1   <= i_tap;
            r_vld2   <= r_tap1.vld;
            r_first2 <= r_tap1.first;
            r_last2  <= r_tap1.last;
            r_done   <= r_vld2 && r_last2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (r_vld2) begin
            r_acc <= n_acc;
        end
    end

    assign o_done  = r_done;
    assign o_value = r_acc[bis_pkg::ACC_W-1 -: bis_pkg::PIX_W];

endmodule

>>> hdl/bilinear_image_sampler_top.sv
// Top level of the bilinear image sampler: control, bounds, weights and output register.
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) takes one word: a pixel write
//   or a Q8.8 bilinear sample. Output channel (o_out_valid / i_out_ready / o_out_word)
//   returns exactly one word per input word, in order.
//   Config port (i_cfg_we, i_cfg_index, i_cfg_data) sets image width/height; write it
//   only while the block is idle.
// Sequencing:
//   A write's result is loaded from S_WRITE, or from S_OUT after a stall; a sample's four
//   neighbor reads go one per cycle through the single-port pixel memory and then
//   through a multiply and an accumulate stage. The block takes a new word in the
//   cycle after the previous result enters the output register.
// Reset:
//   Clears control state and sets width and height to 256. Pixel memory content is
//   not cleared; only written pixels may be sampled.
// Stall:
//   The output register holds a finished word while i_out_ready is low; the next word
//   is still accepted and processed, and its result waits internally until the
//   output register frees.
module bilinear_image_sampler_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  bis_pkg::t_in_word               i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output bis_pkg::t_out_word              o_out_word,
    input  logic                            i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bis_pkg::SIZE_W-1:0]      i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_WAIT,
        S_OUT
    } t_state;

    t_state                          r_state;
    bis_pkg::t_in_word               r_in;
    bis_pkg::t_out_word              r_res;
    bis_pkg::t_out_word              r_out_word;
    logic                            r_out_valid;
    logic [1:0]                      r_cnt;
    logic [bis_pkg::SIZE_W-1:0]      r_width;
    logic [bis_pkg::SIZE_W-1:0]      r_height;

    logic [bis_pkg::CMP_W-1:0]       nx;
    logic [bis_pkg::CMP_W-1:0]       ny;
    logic                            tap_inside;
    logic [bis_pkg::ADDR_W-1:0]      mem_addr;
    logic                            mem_we;
    logic [bis_pkg::PIX_W-1:0]       mem_rdata;
    logic [bis_pkg::FRAC_BITS-1:0]   fx;
    logic [bis_pkg::FRAC_BITS-1:0]   fy;
    logic [bis_pkg::WGT_W-1:0]       wx;
    logic [bis_pkg::WGT_W-1:0]       wy;
    bis_pkg::t_tap                   tap;
    logic                            blend_done;
    logic [bis_pkg::PIX_W-1:0]       blend_value;
    logic                            out_free;
    logic                            out_load;
    bis_pkg::t_out_word              n_res;

    // neighbor r_cnt: bit 0 steps x, bit 1 steps y
    always_comb begin
        nx = bis_pkg::CMP_W'(r_in.x_coord[bis_pkg::COORD_W-1:bis_pkg::FRAC_BITS])
           + bis_pkg::CMP_W'(r_cnt[0]);
        ny = bis_pkg::CMP_W'(r_in.y_coord[bis_pkg::COORD_W-1:bis_pkg::FRAC_BITS])
           + bis_pkg::CMP_W'(r_cnt[1]);
        tap_inside = (nx < bis_pkg::CMP_W'(r_width))
                  && (nx < bis_pkg::CMP_W'(bis_pkg::MAX_WIDTH))
                  && (ny < bis_pkg::CMP_W'(r_height))
                  && (ny < bis_pkg::CMP_W'(bis_pkg::MAX_HEIGHT));
        mem_addr = bis_pkg::ADDR_W'(bis_pkg::ADDR_W'(ny) * bis_pkg::ADDR_W'(bis_pkg::MAX_WIDTH)
                 + bis_pkg::ADDR_W'(nx));
        mem_we = (r_state == S_WRITE) && tap_inside;

        fx = r_in.x_coord[bis_pkg::FRAC_BITS-1:0];
        fy = r_in.y_coord[bis_pkg::FRAC_BITS-1:0];
        wx = r_cnt[0] ? bis_pkg::WGT_W'(fx) : bis_pkg::WGT_ONE - bis_pkg::WGT_W'(fx);
        wy = r_cnt[1] ? bis_pkg::WGT_W'(fy) : bis_pkg::WGT_ONE - bis_pkg::WGT_W'(fy);

        tap.vld    = (r_state == S_READ);
        tap.first  = (r_cnt == 2'd0);
        tap.last   = (r_cnt == 2'd3);
        tap.in_img = tap_inside;
        tap.weight = bis_pkg::W2_W'(wx * wy);

        n_res = '0;
        if (r_state == S_WRITE) begin
            n_res.write_ignored = !tap_inside;
        end else begin
            n_res.sample_value = blend_value;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = out_free && ((r_state == S_WRITE) || (r_state == S_OUT)
                                   || (r_state == S_WAIT && blend_done));

    bis_pixel_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (r_in.pixel_value),
        .o_rdata (mem_rdata)
    );

    bis_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tap   (tap),
        .i_rdata (mem_rdata),
        .o_done  (blend_done),
        .o_value (blend_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bis_pkg::SIZE_DEFAULT;
            r_height <= bis_pkg::SIZE_DEFAULT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bis_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                bis_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= 2'd0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_word;
                        r_cnt   <= 2'd0;
                        r_state <= (i_in_word.command == bis_pkg::CMD_SAMPLE) ? S_READ : S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_res <= n_res;
                    if (out_free) begin
                        r_out_word  <= n_res;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_READ: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (blend_done) begin
                        r_res <= n_res;
                        if (out_free) begin
                            r_out_word  <= n_res;
                            r_state     <= S_IDLE;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_word  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    a_we_only_for_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_in.command == bis_pkg::CMD_WRITE)
        else $error("pixel memory written outside a write word");

    a_done_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blend_done |-> r_state == S_WAIT)
        else $error("blend result arrived while not waiting for it");

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_WRITE || r_state == S_READ))
        else $error("accepted word did not start processing");

    a_ignored_has_no_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.write_ignored) |-> r_out_word.sample_value == '0)
        else $error("ignored write carries a sample value");

    a_read_ends_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && r_cnt == 2'd3) |=> r_state == S_WAIT)
        else $error("neighbor read sequence did not hand over to wait");
`endif

endmodule
